// ----- rtl/core/fdss_pkg.sv -----
// fdss_pkg: shared types, constants and the segment decode for the
// four-digit seven-segment scanner. No dependencies.
package fdss_pkg;

  localparam int NUM_DIGITS = 4;
  localparam int DIGIT_W    = 4;
  localparam int SEG_W      = 7;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [1:0]         func_t;

  localparam func_t FUNC_TICK   = 2'd0;
  localparam func_t FUNC_NUMBER = 2'd1;
  localparam func_t FUNC_TIME   = 2'd2;
  localparam func_t FUNC_DIGIT  = 2'd3;

  localparam digit_t BLANK_CODE = 4'd15;
  localparam seg_t   SEG_OFF    = 7'h7f;

  localparam logic [13:0] MAX_NUMBER = 14'd9999;
  localparam logic [7:0]  MAX_HOUR   = 8'd24;
  localparam logic [7:0]  MAX_MINUTE = 8'd60;

  // Reciprocal constants: exact quotients over the full 14-bit / 8-bit input range
  localparam logic [15:0] RECIP_10   = 16'd52429;  // >> 19
  localparam logic [12:0] RECIP_100  = 13'd5243;   // >> 19
  localparam logic [14:0] RECIP_1000 = 15'd16778;  // >> 24
  localparam logic [7:0]  RECIP_10_8 = 8'd205;     // >> 11

  localparam digit_t STORE_RESET [NUM_DIGITS] = '{4'd8, 4'd9, 4'd0, 4'd1};

  // Segment patterns, bit 6 down to bit 0, active low
  localparam seg_t SEG_TABLE [10] = '{
    7'h01, 7'h4f, 7'h12, 7'h06, 7'h4c, 7'h24, 7'h20, 7'h0f, 7'h00, 7'h04
  };

  // Digit code to segment lines: line k carries pattern bit 6 - k
  function automatic seg_t seg_lines(input digit_t code);
    seg_t pat;
    seg_t lines;
    if (code > 4'd9) begin
      pat = SEG_OFF;
    end else begin
      pat = SEG_TABLE[code];
    end
    for (int k = 0; k < SEG_W; k++) begin
      lines[k] = pat[SEG_W-1-k];
    end
    return lines;
  endfunction

endpackage

// ----- rtl/core/four_digit_seven_segment_scanner.sv -----
// four_digit_seven_segment_scanner: input register, one level of decode and
// digit-split logic, result register. Depends on fdss_pkg.
//
// A result passes the input register, then the result register, before its
// transfer; it can wait in either register while out_ready is low.
// Throughput: one item per cycle while out_ready stays high.
// Reset (rst_n low, synchronous): both stages empty, digit store 8,9,0,1,
// scan position 0, common and segment state all high; result registers not reset.
module four_digit_seven_segment_scanner
  import fdss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [13:0] in_value,
  input  logic [7:0]  in_hour,
  input  logic [7:0]  in_minute,
  input  logic [1:0]  in_digit_position,
  input  logic [7:0]  in_digit_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_segment_lines,
  output logic [3:0]  out_common_lines,
  output logic        out_accepted
);

  // Input stage
  logic        in_v_r;
  func_t       func_r;
  logic [13:0] value_r;
  logic [7:0]  hour_r;
  logic [7:0]  minute_r;
  logic [1:0]  pos_r;
  logic [7:0]  code_r;

  // Block state
  digit_t      store_r   [NUM_DIGITS];
  digit_t      store_nxt [NUM_DIGITS];
  logic [1:0]  scan_r, scan_nxt;
  logic [3:0]  common_r, common_nxt;
  seg_t        segment_r, segment_nxt;
  logic        ok_nxt;

  // Result stage
  logic        out_v_r;
  seg_t        out_seg_r;
  logic [3:0]  out_com_r;
  logic        out_ok_r;

  logic        advance;

  // Number split
  logic [29:0] prod10;
  logic [26:0] prod100;
  logic [28:0] prod1000;
  logic [10:0] q10;
  logic [7:0]  q100;
  logic [4:0]  q1000;
  logic [13:0] ones_w;
  logic [10:0] tens_w;
  logic [7:0]  hund_w;

  // Time split
  logic [15:0] hprod, mprod;
  logic [4:0]  h10, m10;
  logic [7:0]  h1_w, m1_w;

  logic [1:0]  next_pos;
  logic [1:0]  wr_idx;

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r   <= in_func;
      value_r  <= in_value;
      hour_r   <= in_hour;
      minute_r <= in_minute;
      pos_r    <= in_digit_position;
      code_r   <= in_digit_code;
    end
  end

  assign prod10   = {16'd0, value_r} * {14'd0, RECIP_10};
  assign prod100  = {13'd0, value_r} * {14'd0, RECIP_100};
  assign prod1000 = {15'd0, value_r} * {14'd0, RECIP_1000};
  assign q10      = prod10[29:19];
  assign q100     = prod100[26:19];
  assign q1000    = prod1000[28:24];
  assign ones_w   = value_r - ({3'd0, q10} * 14'd10);
  assign tens_w   = q10 - ({3'd0, q100} * 11'd10);
  assign hund_w   = q100 - ({3'd0, q1000} * 8'd10);

  assign hprod = {8'd0, hour_r} * {8'd0, RECIP_10_8};
  assign mprod = {8'd0, minute_r} * {8'd0, RECIP_10_8};
  assign h10   = hprod[15:11];
  assign m10   = mprod[15:11];
  assign h1_w  = hour_r - ({3'd0, h10} * 8'd10);
  assign m1_w  = minute_r - ({3'd0, m10} * 8'd10);

  assign next_pos = scan_r + 2'd1;
  assign wr_idx   = 2'd3 - pos_r;

  always_comb begin
    store_nxt   = store_r;
    scan_nxt    = scan_r;
    common_nxt  = common_r;
    segment_nxt = segment_r;
    ok_nxt      = 1'b1;
    unique case (func_r)
      FUNC_TICK: begin
        // drop the previous common, raise the new one
        scan_nxt    = next_pos;
        common_nxt  = (common_r & ~(4'b0001 << scan_r)) | (4'b0001 << next_pos);
        segment_nxt = seg_lines(store_r[next_pos]);
      end
      FUNC_NUMBER: begin
        if (value_r > MAX_NUMBER) begin
          ok_nxt = 1'b0;
        end else begin
          store_nxt[3] = ones_w[3:0];
          store_nxt[2] = (value_r >= 14'd10)   ? tens_w[3:0] : BLANK_CODE;
          store_nxt[1] = (value_r >= 14'd100)  ? hund_w[3:0] : BLANK_CODE;
          store_nxt[0] = (value_r >= 14'd1000) ? q1000[3:0]  : BLANK_CODE;
        end
      end
      FUNC_TIME: begin
        if (hour_r > MAX_HOUR || minute_r > MAX_MINUTE) begin
          ok_nxt = 1'b0;
        end else begin
          store_nxt[0] = h10[3:0];
          store_nxt[1] = h1_w[3:0];
          store_nxt[2] = m10[3:0];
          store_nxt[3] = m1_w[3:0];
        end
      end
      FUNC_DIGIT: begin
        store_nxt[wr_idx] = (code_r > 8'd9) ? BLANK_CODE : code_r[3:0];
      end
      default: begin
        ok_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r   <= STORE_RESET;
      scan_r    <= 2'd0;
      common_r  <= 4'hf;
      segment_r <= SEG_OFF;
    end else if (advance) begin
      store_r   <= store_nxt;
      scan_r    <= scan_nxt;
      common_r  <= common_nxt;
      segment_r <= segment_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  // hold the result until its transfer
  always_ff @(posedge clk) begin
    if (advance) begin
      out_seg_r <= segment_nxt;
      out_com_r <= common_nxt;
      out_ok_r  <= ok_nxt;
    end
  end

  assign out_valid         = out_v_r;
  assign out_segment_lines = out_seg_r;
  assign out_common_lines  = out_com_r;
  assign out_accepted      = out_ok_r;

endmodule
